/* sv/triangle_count_list_intersect_macros.svh */
// assertion macros shared by the triangle counter rtl
`ifndef TRIANGLE_COUNT_LIST_INTERSECT_MACROS_SVH
`define TRIANGLE_COUNT_LIST_INTERSECT_MACROS_SVH

// same-cycle implication, checked out of reset
`define TCLI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define TCLI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/tcli_pkg.sv */
// shared types and codes of the triangle counter
package tcli_pkg;

	// item modes
	localparam logic [1:0] MODE_OFFSET = 2'd0;
	localparam logic [1:0] MODE_NEIGH  = 2'd1;
	localparam logic [1:0] MODE_EDGE   = 2'd2;

	// field widths
	localparam int INDEX_W  = 13;
	localparam int VALUE_W  = 14;
	localparam int VERTEX_W = 10;
	localparam int COUNT_W  = 32;

	// table write request from the input side
	typedef struct packed {
		logic                wr_en;
		logic [INDEX_W-1:0]  index;
		logic [VALUE_W-1:0]  value;
	} table_wr_t;

	// edge request into the offset lookup
	typedef struct packed {
		logic                start;
		logic [VERTEX_W-1:0] vertex_a;
		logic [VERTEX_W-1:0] vertex_b;
	} edge_req_t;

	// per-cycle status of the merge walk
	typedef struct packed {
		logic hit;
		logic done;
	} walk_status_t;

endpackage

/* sv/tcli_offsets.sv */
// offset store with the list bounds lookup for both edge endpoints
module tcli_offsets #(
	parameter int MAX_VERTICES   = 1024,
	parameter int MAX_NEIGHBOURS = 8192,
	localparam int OA_W = $clog2(MAX_VERTICES + 1),
	localparam int PW   = $clog2(MAX_NEIGHBOURS) + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tcli_pkg::table_wr_t wr,
	input  tcli_pkg::edge_req_t req,
	output logic                bounds_valid,
	output logic [PW-1:0]       a_lo,
	output logic [PW-1:0]       a_hi,
	output logic [PW-1:0]       b_lo,
	output logic [PW-1:0]       b_hi
);

	localparam int DEPTH = MAX_VERTICES + 1;

	localparam logic [1:0] OP_IDLE = 2'd0;
	localparam logic [1:0] OP_A    = 2'd1;
	localparam logic [1:0] OP_B    = 2'd2;

	logic [tcli_pkg::VALUE_W-1:0] mem [DEPTH];
	logic [tcli_pkg::VALUE_W-1:0] rd_lo_q, rd_hi_q;
	logic [1:0]                   phase_q;
	logic [tcli_pkg::VERTEX_W-1:0] vb_q;
	logic                         a_ok_q, b_ok_q;
	logic [OA_W-1:0]              raddr_lo, raddr_hi;
	logic [tcli_pkg::VERTEX_W-1:0] rd_vertex;
	logic                         wr_hit;
	logic [PW-1:0]                lo_c, hi_c, e_c;
	logic                         ok_c;
	logic                         valid_q;
	logic [PW-1:0]                a_lo_q, a_hi_q, b_lo_q, b_hi_q;

	// clamp an offset to the neighbour store size
	function automatic logic [PW-1:0] clamp_off(input logic [tcli_pkg::VALUE_W-1:0] off);
		logic [PW-1:0] r;
		if (32'(off) > 32'(MAX_NEIGHBOURS)) r = PW'(MAX_NEIGHBOURS);
		else r = PW'(off);
		return r;
	endfunction

	// read the start and end offsets of a in idle, of b in phase a
	assign rd_vertex = (phase_q == OP_IDLE) ? req.vertex_a : vb_q;
	assign raddr_lo  = OA_W'(32'(rd_vertex));
	assign raddr_hi  = OA_W'(32'(rd_vertex) + 32'd1);
	assign wr_hit    = wr.wr_en && (32'(wr.index) <= 32'(MAX_VERTICES));

	// offset memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (wr_hit) mem[OA_W'(wr.index)] <= wr.value;
		rd_lo_q <= mem[raddr_lo];
		rd_hi_q <= mem[raddr_hi];
	end

	// bounds of the list just read
	assign ok_c = (phase_q == OP_A) ? a_ok_q : b_ok_q;
	always_comb begin
		lo_c = '0;
		hi_c = '0;
		e_c  = clamp_off(rd_hi_q);
		if (ok_c) begin
			lo_c = clamp_off(rd_lo_q);
			hi_c = (e_c < lo_c) ? lo_c : e_c;
		end
	end

	// lookup sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= OP_IDLE;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (phase_q)
				OP_IDLE: begin
					if (req.start) phase_q <= OP_A;
				end
				OP_A: begin
					phase_q <= OP_B;
				end
				OP_B: begin
					phase_q <= OP_IDLE;
					valid_q <= 1'b1;
				end
				default: begin
					phase_q <= OP_IDLE;
				end
			endcase
		end
	end

	// captured endpoints and bounds
	always_ff @(posedge clk) begin
		if (phase_q == OP_IDLE && req.start) begin
			vb_q   <= req.vertex_b;
			a_ok_q <= 32'(req.vertex_a) < 32'(MAX_VERTICES);
			b_ok_q <= 32'(req.vertex_b) < 32'(MAX_VERTICES);
		end
		if (phase_q == OP_A) begin
			a_lo_q <= lo_c;
			a_hi_q <= hi_c;
		end
		if (phase_q == OP_B) begin
			b_lo_q <= lo_c;
			b_hi_q <= hi_c;
		end
	end

	assign bounds_valid = valid_q;
	assign a_lo = a_lo_q;
	assign a_hi = a_hi_q;
	assign b_lo = b_lo_q;
	assign b_hi = b_hi_q;

endmodule

/* sv/tcli_merge.sv */
// neighbour store with the merge walk over two sorted lists
module tcli_merge #(
	parameter int MAX_NEIGHBOURS = 8192,
	localparam int NA_W = $clog2(MAX_NEIGHBOURS),
	localparam int PW   = NA_W + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tcli_pkg::table_wr_t    wr,
	input  logic                   start,
	input  logic [PW-1:0]          a_lo,
	input  logic [PW-1:0]          a_hi,
	input  logic [PW-1:0]          b_lo,
	input  logic [PW-1:0]          b_hi,
	output tcli_pkg::walk_status_t status
);

	localparam int NV_W = tcli_pkg::VERTEX_W;

	logic [NV_W-1:0] mem [MAX_NEIGHBOURS];
	logic [NV_W-1:0] x_q, y_q;
	logic [PW-1:0]   i_q, ie_q, j_q, je_q;
	logic [PW-1:0]   i_nxt, j_nxt;
	logic [PW-1:0]   ra, rb;
	logic            active_q;
	logic            run;
	logic            wr_hit;

	assign wr_hit = wr.wr_en && (32'(wr.index) < 32'(MAX_NEIGHBOURS));

	// one compare a cycle on the registered read data
	assign run = active_q && (i_q < ie_q) && (j_q < je_q);
	always_comb begin
		i_nxt = i_q;
		j_nxt = j_q;
		if (run) begin
			if (x_q <= y_q) i_nxt = i_q + PW'(1);
			if (x_q >= y_q) j_nxt = j_q + PW'(1);
		end
	end

	// read addresses for the next compare
	assign ra = start ? a_lo : i_nxt;
	assign rb = start ? b_lo : j_nxt;

	// neighbour memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (wr_hit) mem[NA_W'(wr.index)] <= wr.value[NV_W-1:0];
		x_q <= mem[NA_W'(ra)];
		y_q <= mem[NA_W'(rb)];
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (start) begin
			active_q <= 1'b1;
		end else if (active_q && !run) begin
			active_q <= 1'b0;
		end
	end

	// list pointers
	always_ff @(posedge clk) begin
		i_q <= ra;
		j_q <= rb;
		if (start) begin
			ie_q <= a_hi;
			je_q <= b_hi;
		end
	end

	assign status.hit  = run && (x_q == y_q);
	assign status.done = active_q && !run;

endmodule

/* sv/triangle_count_list_intersect.sv */
// top level of the triangle counter by sorted neighbour list intersection
//
// Usage: one input channel (item_valid, item_stall) carries load and edge items;
// one result channel (result_valid, result_stall) carries chunk counts.
// A transfer happens at a clock edge with valid high and stall low.
// Offset and neighbour loads (modes 0 and 1) and ignored mode 3 leave item_stall low.
// An edge item (mode 2) reads the offsets of a, then of b, and then runs the
// merge walk, whose compares number at most the sum of both list lengths;
// when the edge is last in its chunk, an emit step hands over the count.
// The walk does one compare a cycle on both read ports of the neighbour memory.
// Only one item is in flight; item_stall is high while an edge is at work.
// A finished count waits in the output register; loads and further edges
// go on meanwhile, and a last edge holds until that register is free.
// The count saturates at all ones and clears when it moves to the output register.
// Reset clears the control state, the count and result_valid; the offset and
// neighbour memories keep no reset and must be loaded before use.
module triangle_count_list_intersect #(
	parameter int MAX_VERTICES   = 1024,
	parameter int MAX_NEIGHBOURS = 8192
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [1:0]                         mode,
	input  logic [tcli_pkg::INDEX_W-1:0]       table_index,
	input  logic [tcli_pkg::VALUE_W-1:0]       table_value,
	input  logic [tcli_pkg::VERTEX_W-1:0]      vertex_a,
	input  logic [tcli_pkg::VERTEX_W-1:0]      vertex_b,
	input  logic                               last_in_chunk,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [tcli_pkg::COUNT_W-1:0]       triangle_count
);

	localparam int PW = $clog2(MAX_NEIGHBOURS) + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EDGE = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                     state_q;
	logic                           last_q;
	logic [tcli_pkg::COUNT_W-1:0]   count_q;
	logic [tcli_pkg::COUNT_W-1:0]   out_q;
	logic                           result_valid_q;
	logic                           accept;
	logic                           out_free;
	logic                           emit_go;
	tcli_pkg::table_wr_t            off_wr, nb_wr;
	tcli_pkg::edge_req_t            req;
	tcli_pkg::walk_status_t         st;
	logic                           bounds_valid;
	logic [PW-1:0]                  a_lo, a_hi, b_lo, b_hi;

	// input transfer and requests to the stores
	assign accept = item_valid && (state_q == ST_IDLE);
	assign off_wr = '{wr_en: accept && (mode == tcli_pkg::MODE_OFFSET),
		index: table_index, value: table_value};
	assign nb_wr = '{wr_en: accept && (mode == tcli_pkg::MODE_NEIGH),
		index: table_index, value: table_value};
	assign req = '{start: accept && (mode == tcli_pkg::MODE_EDGE),
		vertex_a: vertex_a, vertex_b: vertex_b};

	tcli_offsets #(
		.MAX_VERTICES   (MAX_VERTICES),
		.MAX_NEIGHBOURS (MAX_NEIGHBOURS)
	) u_offsets (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr           (off_wr),
		.req          (req),
		.bounds_valid (bounds_valid),
		.a_lo         (a_lo),
		.a_hi         (a_hi),
		.b_lo         (b_lo),
		.b_hi         (b_hi)
	);

	tcli_merge #(
		.MAX_NEIGHBOURS (MAX_NEIGHBOURS)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (nb_wr),
		.start  (bounds_valid),
		.a_lo   (a_lo),
		.a_hi   (a_hi),
		.b_lo   (b_lo),
		.b_hi   (b_hi),
		.status (st)
	);

	assign out_free = !result_valid_q || !result_stall;
	assign emit_go  = (state_q == ST_EMIT) && out_free;

	// edge sequencer and running count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						state_q <= ST_EDGE;
						last_q  <= last_in_chunk;
					end
				end
				ST_EDGE: begin
					if (st.hit && (count_q != '1)) count_q <= count_q + 32'd1;
					if (st.done) state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						count_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_go) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) out_q <= count_q;
	end

	assign item_stall     = (state_q != ST_IDLE);
	assign result_valid   = result_valid_q;
	assign triangle_count = out_q;

	`include "triangle_count_list_intersect_macros.svh"

	`TCLI_ASSERT_NOW(a_hit_in_edge, st.hit || st.done, state_q == ST_EDGE, "walk status outside edge")
	`TCLI_ASSERT_NEXT(a_emit_clears, emit_go, (count_q == '0) && result_valid_q, "emit did not clear")
	`TCLI_ASSERT_NOW(a_emit_last, state_q == ST_EMIT, last_q, "emit without last flag")
	`TCLI_ASSERT_NOW(a_bounds_in_edge, bounds_valid, state_q == ST_EDGE, "bounds outside edge")

endmodule

/* tb/triangle_count_list_intersect_tb.sv */
// testbench of the triangle counter: graph loads and edges, checked per chunk count
module triangle_count_list_intersect_tb;

	localparam int MAX_VERTICES   = 1024;
	localparam int MAX_NEIGHBOURS = 8192;
	localparam int CLK_PERIOD     = 10;
	localparam int TARGET_ITEMS   = 1950;
	localparam int MIN_RESULTS    = 48;
	localparam int CALM_ITEMS     = 150;
	localparam int DRAIN_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int POOL_SIZE      = 12;
	localparam int INDEX_W        = tcli_pkg::INDEX_W;
	localparam int VALUE_W        = tcli_pkg::VALUE_W;
	localparam int VERTEX_W       = tcli_pkg::VERTEX_W;
	localparam int COUNT_W        = tcli_pkg::COUNT_W;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]          mode;
		logic [INDEX_W-1:0]  tbl_index;
		logic [VALUE_W-1:0]  tbl_value;
		logic [VERTEX_W-1:0] va;
		logic [VERTEX_W-1:0] vb;
		logic                last;
	} item_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                item_valid    = 1'b0;
	logic                item_stall;
	logic [1:0]          mode          = '0;
	logic [INDEX_W-1:0]  table_index   = '0;
	logic [VALUE_W-1:0]  table_value   = '0;
	logic [VERTEX_W-1:0] vertex_a      = '0;
	logic [VERTEX_W-1:0] vertex_b      = '0;
	logic                last_in_chunk = 1'b0;
	logic                result_valid;
	logic                result_stall  = 1'b0;
	logic [COUNT_W-1:0]  triangle_count;

	// predicted graph tables, with a mark for every entry that has been loaded
	bit [VALUE_W-1:0]  offset_mem [0:MAX_VERTICES];
	bit                offset_set [0:MAX_VERTICES];
	bit [VERTEX_W-1:0] neigh_mem [0:MAX_NEIGHBOURS-1];
	bit                neigh_set [0:MAX_NEIGHBOURS-1];
	bit [COUNT_W-1:0]  chunk_count;

	item_t              pending_items [$];
	logic [COUNT_W-1:0] expected_counts [$];
	item_t              drive_item;
	logic [COUNT_W-1:0] want_count;
	int                 useful_items;
	int                 results_planned;
	int                 error_count;
	int                 gap_left;
	int                 stall_left;
	int                 quiet_cycles;

	triangle_count_list_intersect #(
		.MAX_VERTICES   (MAX_VERTICES),
		.MAX_NEIGHBOURS (MAX_NEIGHBOURS)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.mode           (mode),
		.table_index    (table_index),
		.table_value    (table_value),
		.vertex_a       (vertex_a),
		.vertex_b       (vertex_b),
		.last_in_chunk  (last_in_chunk),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.triangle_count (triangle_count)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	// list bounds of a vertex, clamped to the neighbour store, empty when descending
	function automatic void list_span(input int v, output int lo, output int hi);
		if (v >= MAX_VERTICES) begin
			lo = 0;
			hi = 0;
			return;
		end
		lo = int'(offset_mem[v]);
		hi = int'(offset_mem[v+1]);
		if (lo > MAX_NEIGHBOURS) lo = MAX_NEIGHBOURS;
		if (hi > MAX_NEIGHBOURS) hi = MAX_NEIGHBOURS;
		if (hi < lo) hi = lo;
	endfunction

	// true when every entry the walk of this vertex reads has been loaded
	function automatic bit span_loaded(input int v);
		int lo, hi;
		if (v >= MAX_VERTICES) return 1'b1;
		if (!offset_set[v] || !offset_set[v+1]) return 1'b0;
		list_span(v, lo, hi);
		for (int k = lo; k < hi; k++)
			if (!neigh_set[k]) return 1'b0;
		return 1'b1;
	endfunction

	// merge walk of two sorted lists
	function automatic int unsigned common_neighbours(input int va, input int vb);
		int i, ie, j, je;
		int unsigned hits;
		hits = 0;
		list_span(va, i, ie);
		list_span(vb, j, je);
		while (i < ie && j < je) begin
			if (neigh_mem[i] < neigh_mem[j]) begin
				i++;
			end else if (neigh_mem[i] > neigh_mem[j]) begin
				j++;
			end else begin
				i++;
				j++;
				hits++;
			end
		end
		return hits;
	endfunction

	// every field random, callers override what the mode uses
	function automatic item_t random_fields();
		item_t it;
		it.mode      = 2'($urandom_range(0, 3));
		it.tbl_index = INDEX_W'($urandom);
		it.tbl_value = VALUE_W'($urandom);
		it.va        = VERTEX_W'($urandom);
		it.vb        = VERTEX_W'($urandom);
		it.last      = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// apply one item to the predicted state and queue it for the driver
	task automatic queue_item(input item_t it);
		int unsigned hits;
		case (it.mode)
			tcli_pkg::MODE_OFFSET: begin
				if (int'(it.tbl_index) <= MAX_VERTICES) begin
					offset_mem[it.tbl_index] = it.tbl_value;
					offset_set[it.tbl_index] = 1'b1;
					useful_items++;
				end
			end
			tcli_pkg::MODE_NEIGH: begin
				if (int'(it.tbl_index) < MAX_NEIGHBOURS) begin
					neigh_mem[it.tbl_index] = it.tbl_value[VERTEX_W-1:0];
					neigh_set[it.tbl_index] = 1'b1;
				end
				useful_items++;
			end
			tcli_pkg::MODE_EDGE: begin
				hits = common_neighbours(int'(it.va), int'(it.vb));
				if (chunk_count > 32'hFFFF_FFFF - hits) chunk_count = '1;
				else chunk_count = chunk_count + hits;
				if (it.last) begin
					expected_counts.push_back(chunk_count);
					chunk_count = '0;
					results_planned++;
				end
				useful_items++;
			end
			default: ;
		endcase
		pending_items.push_back(it);
	endtask

	task automatic push_load(input logic [1:0] m, input int idx, input int val);
		item_t it;
		it           = random_fields();
		it.mode      = m;
		it.tbl_index = INDEX_W'(idx);
		it.tbl_value = VALUE_W'(val);
		queue_item(it);
	endtask

	task automatic push_edge(input int va, input int vb, input bit last);
		item_t it;
		it      = random_fields();
		it.mode = tcli_pkg::MODE_EDGE;
		it.va   = VERTEX_W'(va);
		it.vb   = VERTEX_W'(vb);
		it.last = last;
		queue_item(it);
	endtask

	// unused mode, ignored slots and stray table writes
	task automatic push_noise();
		item_t it;
		it = random_fields();
		case ($urandom_range(0, 3))
			0: it.mode = MODE_UNUSED;
			1: begin
				it.mode      = tcli_pkg::MODE_OFFSET;
				it.tbl_index = INDEX_W'($urandom_range(MAX_VERTICES + 1, 2**INDEX_W - 1));
			end
			2: it.mode = tcli_pkg::MODE_NEIGH;
			default: begin
				it.mode      = tcli_pkg::MODE_OFFSET;
				it.tbl_index = INDEX_W'($urandom_range(0, MAX_VERTICES));
			end
		endcase
		queue_item(it);
	endtask

	// one partition: a window of vertices with sorted lists drawn from a shared pool
	task automatic load_partition(output int base, output int n);
		int pool [0:POOL_SIZE-1];
		int deg [0:POOL_SIZE-1];
		int ids [$];
		int nb, pos;
		n    = $urandom_range(2, 12);
		base = $urandom_range(0, MAX_VERTICES - n);
		pool[0] = $urandom_range(0, 40);
		for (int k = 1; k < POOL_SIZE - 1; k++) pool[k] = pool[k-1] + $urandom_range(1, 85);
		pool[POOL_SIZE-1] = 2**VERTEX_W - 1 - $urandom_range(0, 40);
		for (int v = 0; v < n; v++) begin
			deg[v] = 0;
			for (int k = 0; k < POOL_SIZE; k++) begin
				if ($urandom_range(0, 2) == 0) begin
					ids.push_back(pool[k]);
					deg[v]++;
				end
			end
		end
		nb  = $urandom_range(0, MAX_NEIGHBOURS - ids.size());
		pos = nb;
		for (int v = 0; v <= n; v++) begin
			push_load(tcli_pkg::MODE_OFFSET, base + v, pos);
			if (v < n) pos += deg[v];
		end
		for (int k = 0; k < ids.size(); k++)
			push_load(tcli_pkg::MODE_NEIGH, nb + k,
				int'($urandom_range(0, 15) << VERTEX_W) | ids[k]);
	endtask

	// stimulus, reset and end of run
	initial begin
		int base, n, va, vb;
		error_count     = 0;
		useful_items    = 0;
		results_planned = 0;
		chunk_count     = '0;

		// two short lists sharing two ids, edges between them and of the second against itself
		push_load(tcli_pkg::MODE_OFFSET, 0, 0);
		push_load(tcli_pkg::MODE_OFFSET, 1, 3);
		push_load(tcli_pkg::MODE_OFFSET, 2, 6);
		push_load(tcli_pkg::MODE_NEIGH, 0, 1);
		push_load(tcli_pkg::MODE_NEIGH, 1, 5);
		push_load(tcli_pkg::MODE_NEIGH, 2, 2**VALUE_W - 1);
		push_load(tcli_pkg::MODE_NEIGH, 3, 0);
		push_load(tcli_pkg::MODE_NEIGH, 4, 5);
		push_load(tcli_pkg::MODE_NEIGH, 5, 2**VERTEX_W - 1);
		push_edge(0, 1, 1'b0);
		push_edge(1, 1, 1'b1);
		// unused mode with the last flag, and an offset slot past the table
		begin
			item_t it;
			it      = random_fields();
			it.mode = MODE_UNUSED;
			it.last = 1'b1;
			queue_item(it);
		end
		push_load(tcli_pkg::MODE_OFFSET, 2**INDEX_W - 1, 2**VALUE_W - 1);
		push_load(tcli_pkg::MODE_NEIGH, 6, 7);
		// descending offsets on the top vertex give an empty list
		push_load(tcli_pkg::MODE_OFFSET, MAX_VERTICES - 1, 5);
		push_load(tcli_pkg::MODE_OFFSET, MAX_VERTICES, 2);
		push_edge(MAX_VERTICES - 1, 0, 1'b1);
		push_edge(0, MAX_VERTICES - 1, 1'b1);
		// end offset past the store is clamped to the store size
		push_load(tcli_pkg::MODE_OFFSET, 3, MAX_NEIGHBOURS - 2);
		push_load(tcli_pkg::MODE_OFFSET, 4, 2**VALUE_W - 1);
		push_load(tcli_pkg::MODE_NEIGH, MAX_NEIGHBOURS - 2, 5);
		push_load(tcli_pkg::MODE_NEIGH, MAX_NEIGHBOURS - 1, 2**VERTEX_W - 1);
		push_edge(3, 1, 1'b1);

		// random partitions, each followed by a burst of edges and noise items
		while (useful_items < TARGET_ITEMS || results_planned < MIN_RESULTS) begin
			load_partition(base, n);
			repeat ($urandom_range(6, 30)) begin
				if ($urandom_range(0, 11) == 0) begin
					push_noise();
				end else begin
					va = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_VERTICES - 1)
						: base + $urandom_range(0, n - 1);
					vb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_VERTICES - 1)
						: base + $urandom_range(0, n - 1);
					if (!span_loaded(va)) va = base + $urandom_range(0, n - 1);
					if (!span_loaded(vb)) vb = base + $urandom_range(0, n - 1);
					if (span_loaded(va) && span_loaded(vb))
						push_edge(va, vb, $urandom_range(0, 3) == 0);
				end
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || item_valid) @(negedge clk);
		while (expected_counts.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (expected_counts.size() != 0)
			report_mismatch($sformatf("%0d counts never arrived", expected_counts.size()));
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// driver: one item per transfer, random gaps except near the end
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			gap_left   <= 0;
		end else if (!item_valid || !item_stall) begin
			if (gap_left > 0) begin
				item_valid <= 1'b0;
				gap_left   <= gap_left - 1;
			end else if (pending_items.size() != 0) begin
				drive_item     = pending_items.pop_front();
				item_valid    <= 1'b1;
				mode          <= drive_item.mode;
				table_index   <= drive_item.tbl_index;
				table_value   <= drive_item.tbl_value;
				vertex_a      <= drive_item.va;
				vertex_b      <= drive_item.vb;
				last_in_chunk <= drive_item.last;
				if (pending_items.size() > CALM_ITEMS && $urandom_range(0, 5) == 0)
					gap_left <= $urandom_range(1, 13);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// monitor: check each count transfer and stall in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_counts.size() == 0) begin
					report_mismatch($sformatf("count %0d with none expected", triangle_count));
				end else begin
					want_count = expected_counts.pop_front();
					if (triangle_count !== want_count)
						report_mismatch($sformatf("triangle_count %0d, expected %0d",
							triangle_count, want_count));
				end
			end
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left   <= stall_left - 1;
			end else if (pending_items.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				stall_left   <= $urandom_range(0, 12);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

/* filelist.f */
+incdir+sv
sv/tcli_pkg.sv
sv/tcli_offsets.sv
sv/tcli_merge.sv
sv/triangle_count_list_intersect.sv
tb/triangle_count_list_intersect_tb.sv
